// ===== rtl/r2p_pkg.sv =====
`timescale 1ns / 1ps

package r2p_pkg;

   localparam int FRAME_WIDTH_DEFAULT  = 128;
   localparam int FRAME_HEIGHT_DEFAULT = 32;

   localparam int PIXEL_W        = 8;
   localparam int COLUMN_BYTE_W  = 8;
   localparam int PAGE_INDEX_W   = 2;
   localparam int COLUMN_INDEX_W = 7;

   // Eight rows per band; the partial store keeps every bit but the bottom one.
   localparam int BAND_BITS   = 3;
   localparam int PARTIAL_W   = COLUMN_BYTE_W - 1;
   localparam logic [BAND_BITS-1:0] BAND_FIRST_ROW = '0;
   localparam logic [BAND_BITS-1:0] BAND_LAST_ROW  = '1;

endpackage

// ===== rtl/r2p_ram.sv =====
`timescale 1ns / 1ps

module r2p_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/raster_to_page_column_packer.sv =====
`timescale 1ns / 1ps

// Raster to page column packer.
// The req channel carries one pixel per item in raster order, top row first and
// each row left to right; any nonzero value is a lit pixel. The rsp channel
// carries one packed column byte per item (bit 0 is the top row of the band)
// with its page and column, and frame_end marks the byte holding the frame's
// last pixel. A byte leaves when the bottom row of its band arrives, or at the
// last row of the frame for a short final band, so the bytes come out in
// page-major order.
// One pixel is accepted every clock while req_stall is low. The edge that accepts
// a byte's last pixel captures that pixel and reads the column store; the byte then
// moves from the pixel stage into the output register, which drives rsp.
// Reset clears the row and column counters and empties the pipeline; the column
// store is not cleared, since each band starts by overwriting its entry.
// While rsp_stall is high the output register holds its byte, and req keeps
// accepting pixels until a second finished byte is waiting in the pipeline.

module raster_to_page_column_packer
   import r2p_pkg::*;
#(
   parameter int FRAME_WIDTH  = FRAME_WIDTH_DEFAULT,
   parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PIXEL_W-1:0]        req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [COLUMN_BYTE_W-1:0]  rsp_column_byte,
   output logic [PAGE_INDEX_W-1:0]   rsp_page_index,
   output logic [COLUMN_INDEX_W-1:0] rsp_column_index,
   output logic                      rsp_frame_end
);

   localparam int ColW = $clog2(FRAME_WIDTH);
   localparam int RowW = $clog2(FRAME_HEIGHT);
   localparam logic [ColW-1:0] ColLast = ColW'(FRAME_WIDTH - 1);
   localparam logic [RowW-1:0] RowLast = RowW'(FRAME_HEIGHT - 1);

   logic                      req_accept;
   logic [ColW-1:0]           column_count_ff, column_count_in;
   logic [RowW-1:0]           row_count_ff, row_count_in;

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_lit_ff;
   logic [ColW-1:0]           s1_col_ff;
   logic [RowW-1:0]           s1_row_ff;

   logic [PARTIAL_W-1:0]      partial_rd;
   logic [COLUMN_BYTE_W-1:0]  lit_shift;
   logic [COLUMN_BYTE_W-1:0]  packed_byte;
   logic                      s1_last_row;
   logic                      s1_last_col;
   logic                      s1_emit;
   logic                      s1_advance;
   logic                      out_load;
   logic                      store_wr_en;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_BYTE_W-1:0]  rsp_column_byte_ff;
   logic [PAGE_INDEX_W-1:0]   rsp_page_index_ff;
   logic [COLUMN_INDEX_W-1:0] rsp_column_index_ff;
   logic                      rsp_frame_end_ff;

   assign req_accept = req_valid && !req_stall;

   // Raster position of the next pixel.
   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (req_accept) begin
         if (column_count_ff == ColLast) begin
            column_count_in = '0;
            row_count_in    = (row_count_ff == RowLast) ? '0 : row_count_ff + 1'b1;
         end else begin
            column_count_in = column_count_ff + 1'b1;
         end
      end
   end

   // Pixel stage: the column store is read while the pixel is captured.
   assign s1_last_row = (s1_row_ff == RowLast);
   assign s1_last_col = (s1_col_ff == ColLast);
   assign s1_emit     = (s1_row_ff[BAND_BITS-1:0] == BAND_LAST_ROW) || s1_last_row;
   assign out_load    = !rsp_valid_ff || !rsp_stall;
   assign s1_advance  = s1_valid_ff && (!s1_emit || out_load);
   assign req_stall   = s1_valid_ff && !s1_advance;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);

   assign lit_shift = COLUMN_BYTE_W'(s1_lit_ff) << s1_row_ff[BAND_BITS-1:0];

   always_comb begin
      if (s1_row_ff[BAND_BITS-1:0] == BAND_FIRST_ROW) begin
         packed_byte = COLUMN_BYTE_W'(s1_lit_ff);
      end else begin
         packed_byte = {1'b0, partial_rd} | lit_shift;
      end
   end

   assign store_wr_en = s1_advance && !s1_emit;

   r2p_ram #(
      .WIDTH (PARTIAL_W),
      .DEPTH (FRAME_WIDTH)
   ) u_partial_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (packed_byte[PARTIAL_W-1:0]),
      .rd_en   (req_accept),
      .rd_addr (column_count_ff),
      .rd_data (partial_rd)
   );

   assign rsp_valid_in = out_load ? (s1_valid_ff && s1_emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_lit_ff <= (req_pixel != '0);
         s1_col_ff <= column_count_ff;
         s1_row_ff <= row_count_ff;
      end
      if (out_load && s1_valid_ff && s1_emit) begin
         rsp_column_byte_ff  <= packed_byte;
         rsp_page_index_ff   <= PAGE_INDEX_W'(s1_row_ff >> BAND_BITS);
         rsp_column_index_ff <= COLUMN_INDEX_W'(s1_col_ff);
         rsp_frame_end_ff    <= s1_last_row && s1_last_col;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_column_byte  = rsp_column_byte_ff;
   assign rsp_page_index   = rsp_page_index_ff;
   assign rsp_column_index = rsp_column_index_ff;
   assign rsp_frame_end    = rsp_frame_end_ff;

   a_column_in_range : assert property (@(posedge clock) disable iff (reset)
      column_count_ff <= ColLast)
      else $error("Column counter left the frame.");

   a_row_in_range : assert property (@(posedge clock) disable iff (reset)
      row_count_ff <= RowLast)
      else $error("Row counter left the frame.");

   a_store_write_not_bottom : assert property (@(posedge clock) disable iff (reset)
      store_wr_en |-> (s1_row_ff[BAND_BITS-1:0] != BAND_LAST_ROW) && !s1_last_row)
      else $error("Finished byte written back to the column store.");

   a_frame_end_last_column : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_frame_end_ff |->
         rsp_column_index_ff == COLUMN_INDEX_W'(FRAME_WIDTH - 1))
      else $error("Frame end flagged away from the last column.");

   a_emit_loads_output : assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_emit |=> rsp_valid_ff)
      else $error("Finished byte left the pixel stage without reaching the output.");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench
   import r2p_pkg::*;
();

   localparam int FRAME_W      = FRAME_WIDTH_DEFAULT;
   localparam int FRAME_H      = FRAME_HEIGHT_DEFAULT;
   localparam int PIXEL_COUNT  = 1300;
   localparam int PHASE_LEN    = 256;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [COLUMN_BYTE_W-1:0]  column_byte;
      logic [PAGE_INDEX_W-1:0]   page_index;
      logic [COLUMN_INDEX_W-1:0] column_index;
      logic                      frame_end;
   } column_byte_type;

   class scoreboard_type;
      logic [PARTIAL_W-1:0] partial_bits [FRAME_W];
      int                   column_at;
      int                   row_at;
      column_byte_type      pending_bytes [$];
      int                   failures;

      function new();
         column_at = 0;
         row_at    = 0;
         failures  = 0;
      endfunction

      function void note_pixel(logic [PIXEL_W-1:0] pixel);
         logic [BAND_BITS-1:0]     band_row;
         logic [COLUMN_BYTE_W-1:0] lit_mask;
         logic [COLUMN_BYTE_W-1:0] packed_byte;
         logic                     last_row;
         logic                     last_column;
         column_byte_type          done;
         band_row = row_at[BAND_BITS-1:0];
         lit_mask = '0;
         lit_mask[band_row] = (pixel != '0);
         if (band_row == BAND_FIRST_ROW) begin
            packed_byte = lit_mask;
         end else begin
            packed_byte = {1'b0, partial_bits[column_at]} | lit_mask;
         end
         last_row    = (row_at >= FRAME_H - 1);
         last_column = (column_at >= FRAME_W - 1);
         if (band_row == BAND_LAST_ROW || last_row) begin
            done.column_byte  = packed_byte;
            done.page_index   = PAGE_INDEX_W'(row_at >> BAND_BITS);
            done.column_index = COLUMN_INDEX_W'(column_at);
            done.frame_end    = last_row && last_column;
            pending_bytes.push_back(done);
         end else begin
            partial_bits[column_at] = packed_byte[PARTIAL_W-1:0];
         end
         if (last_column) begin
            column_at = 0;
            row_at    = last_row ? 0 : row_at + 1;
         end else begin
            column_at = column_at + 1;
         end
      endfunction

      function void check_byte(column_byte_type got);
         column_byte_type want;
         if (pending_bytes.size() == 0) begin
            if (failures < REPORT_LIMIT) begin
               $display("unexpected item: byte %h page %0d column %0d frame_end %0b",
                        got.column_byte, got.page_index, got.column_index, got.frame_end);
            end
            failures++;
         end else begin
            want = pending_bytes.pop_front();
            if (got.column_byte !== want.column_byte || got.page_index !== want.page_index ||
                got.column_index !== want.column_index || got.frame_end !== want.frame_end) begin
               if (failures < REPORT_LIMIT) begin
                  $display("mismatch: expected byte %h page %0d column %0d frame_end %0b",
                           want.column_byte, want.page_index, want.column_index,
                           want.frame_end);
                  $display("          actual   byte %h page %0d column %0d frame_end %0b",
                           got.column_byte, got.page_index, got.column_index, got.frame_end);
               end
               failures++;
            end
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [PIXEL_W-1:0]        req_pixel = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [COLUMN_BYTE_W-1:0]  rsp_column_byte;
   logic [PAGE_INDEX_W-1:0]   rsp_page_index;
   logic [COLUMN_INDEX_W-1:0] rsp_column_index;
   logic                      rsp_frame_end;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;

   scoreboard_type board = new();

   logic [PIXEL_W-1:0] directed_pixels [20] = '{
      8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hFF,
      8'hFE, 8'h7F, 8'h55, 8'hAA, 8'h03, 8'h00, 8'hFF, 8'h01, 8'hC8, 8'h00
   };

   raster_to_page_column_packer #(
      .FRAME_WIDTH  (FRAME_W),
      .FRAME_HEIGHT (FRAME_H)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_column_byte  (rsp_column_byte),
      .rsp_page_index   (rsp_page_index),
      .rsp_column_index (rsp_column_index),
      .rsp_frame_end    (rsp_frame_end)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            board.check_byte({rsp_column_byte, rsp_page_index, rsp_column_index, rsp_frame_end});
         end
         if (req_valid && !req_stall) begin
            board.note_pixel(req_pixel);
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles = quiet_cycles + 1;
         end
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("** raster_to_page_column_packer: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [PIXEL_W-1:0] pixel);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         req_pixel <= PIXEL_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      int                 sent;
      logic [PIXEL_W-1:0] pixel;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
      for (sent = $size(directed_pixels); sent < PIXEL_COUNT; sent++) begin
         case ((sent / PHASE_LEN) % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 46;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 46;
            end
            default: begin
               sender_idle_pct    = 21;
               receiver_stall_pct = 21;
            end
         endcase
         case ($urandom_range(9))
            0, 1, 2, 3: pixel = '0;
            4, 5:       pixel = 8'h01;
            6:          pixel = '1;
            default:    pixel = PIXEL_W'($urandom);
         endcase
         send_pixel(pixel);
      end
      req_valid <= 1'b0;
      while (board.pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0) begin
         $display("** raster_to_page_column_packer: PASSED **");
      end else begin
         $display("** raster_to_page_column_packer: FAILED **");
      end
      $finish;
   end

endmodule
